// ===== rtl/core/firdf_pkg.sv =====
// ----------------------------------------------------------------------------
// FIR filter package
// Shared transfer types, item modes, register indexes and reset values.
// ----------------------------------------------------------------------------
package firdf_pkg;

  localparam int SAMPLE_W = 16;

  localparam logic [1:0] MODE_FILTER = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic REG_FAULT     = 1'b1;

  localparam logic [6:0] TAP_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [5:0]                 tap_index;
    logic signed [SAMPLE_W-1:0] coefficient;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } result_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ===== rtl/core/firdf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module firdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/firdf_mac.sv =====
// ----------------------------------------------------------------------------
// FIR multiply-accumulate
// Registered product, accumulator, then rounding and saturation to 16 bits.
// ----------------------------------------------------------------------------
module firdf_mac #(
  parameter int ACC_W     = 39,
  parameter int FRAC_BITS = 15
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  firdf_pkg::mac_ctl_t                  ctl,
  input  logic signed [firdf_pkg::SAMPLE_W-1:0] tap,
  input  logic signed [firdf_pkg::SAMPLE_W-1:0] coef,
  output logic                                 done,
  output firdf_pkg::result_t                   res
);

  localparam int PROD_W = 2 * firdf_pkg::SAMPLE_W;
  localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_first;
  logic                     p_last;
  logic signed [ACC_W-1:0]  acc;
  logic                     a_done;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      a_done  <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= ctl.valid;
      a_done  <= p_valid && p_last;
      done    <= a_done;
    end
    p_first <= ctl.first;
    p_last  <= ctl.last;
    prod    <= tap * coef;
    if (p_valid) begin
      acc <= p_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    if (a_done) begin
      if (shifted > SAT_HI) begin
        res.filtered <= 16'sh7fff;
        res.clipped  <= 1'b1;
      end else if (shifted < SAT_LO) begin
        res.filtered <= 16'sh8000;
        res.clipped  <= 1'b1;
      end else begin
        res.filtered <= shifted[firdf_pkg::SAMPLE_W-1:0];
        res.clipped  <= 1'b0;
      end
    end
  end

  assign rounded = acc + ROUND;
  assign shifted = rounded >>> FRAC_BITS;

endmodule

// ===== rtl/core/fir_filter_direct_form_unit.sv =====
// ----------------------------------------------------------------------------
// Direct-form FIR filter
// Delay line and coefficient table in RAM, one shared MAC, APB registers.
// ----------------------------------------------------------------------------
// For a filter item (mode 0) the sequencer walks the n active taps once,
// newest last, reading the old sample and coefficient, writing the shifted
// sample back and feeding one multiply-accumulate per cycle. After reset both
// RAMs are swept to zero before the first item is taken; register writes are
// accepted throughout. The result register lets the next item enter while a
// result waits for its transfer.
module fir_filter_direct_form_unit #(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               item_valid,
  output logic               item_ready,
  input  firdf_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output firdf_pkg::result_t result
);

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int ACC_W = 2 * firdf_pkg::SAMPLE_W + AW + 1;
  localparam int SW    = firdf_pkg::SAMPLE_W;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CLEAR = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

  logic [2:0]          state;
  logic [6:0]          tap_count;
  logic                fault;
  logic [AW-1:0]       sweep;
  logic [AW-1:0]       run_idx;
  logic [AW-1:0]       tap_last;
  logic signed [SW-1:0] sample_q;
  logic                emit_zero;
  logic                s1_valid;
  logic                s1_first;
  logic [AW-1:0]       s1_idx;

  logic                cfg_wr;
  logic                item_take;
  logic                coef_ok;

  logic                dl_we;
  logic [AW-1:0]       dl_waddr;
  logic [SW-1:0]       dl_wdata;
  logic [AW-1:0]       dl_raddr;
  logic [SW-1:0]       dl_rdata;
  logic                cf_we;
  logic [AW-1:0]       cf_waddr;
  logic [SW-1:0]       cf_wdata;
  logic [SW-1:0]       cf_rdata;

  logic signed [SW-1:0] tap_val;
  firdf_pkg::mac_ctl_t  mac_ctl;
  logic                 mac_done;
  firdf_pkg::result_t   mac_res;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == firdf_pkg::REG_FAULT) ? {31'd0, fault} : {25'd0, tap_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= firdf_pkg::TAP_COUNT_RESET;
      fault     <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == firdf_pkg::REG_FAULT) begin
        fault <= pwdata[0];
      end else begin
        tap_count <= pwdata[6:0];
      end
    end
  end

  // Highest active tap index
  always_comb begin
    if (tap_count == 7'd0) begin
      tap_last = '0;
    end else if (32'(tap_count) > 32'(MAX_TAPS)) begin
      tap_last = LAST_ADDR;
    end else begin
      tap_last = AW'(tap_count - 7'd1);
    end
  end

  assign item_ready = (state == ST_IDLE);
  assign item_take  = item_valid && item_ready;
  assign coef_ok    = 32'(item.tap_index) < 32'(MAX_TAPS);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      sweep        <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      if (state == ST_EMIT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          if (sweep == LAST_ADDR) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end
        ST_IDLE: begin
          if (item_take) begin
            priority if (item.mode == firdf_pkg::MODE_FILTER) begin
              state <= fault ? ST_EMIT : ST_RUN;
            end else if (item.mode == firdf_pkg::MODE_CLEAR && !fault) begin
              state <= ST_CLEAR;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RUN: begin
          if (run_idx == '0) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!result_valid || result_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      sample_q  <= item.sample;
      emit_zero <= fault;
      run_idx   <= tap_last;
    end else if (state == ST_RUN) begin
      run_idx <= run_idx - AW'(1);
    end
    s1_idx   <= run_idx;
    s1_first <= (run_idx == tap_last);
    if (state == ST_EMIT && (!result_valid || result_ready)) begin
      result <= emit_zero ? '0 : mac_res;
    end
  end

  // Delay line: tap i takes the old tap i-1, tap 0 the new sample
  assign tap_val  = (s1_idx == '0) ? sample_q : dl_rdata;
  assign dl_raddr = run_idx - AW'(1);

  always_comb begin
    if (state == ST_INIT || state == ST_CLEAR) begin
      dl_we    = 1'b1;
      dl_waddr = sweep;
      dl_wdata = '0;
    end else begin
      dl_we    = s1_valid;
      dl_waddr = s1_idx;
      dl_wdata = tap_val;
    end
  end

  always_comb begin
    if (state == ST_INIT) begin
      cf_we    = 1'b1;
      cf_waddr = sweep;
      cf_wdata = '0;
    end else begin
      cf_we    = item_take && item.mode == firdf_pkg::MODE_LOAD && coef_ok;
      cf_waddr = AW'(item.tap_index);
      cf_wdata = item.coefficient;
    end
  end

  firdf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  firdf_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (run_idx),
    .rdata (cf_rdata)
  );

  assign mac_ctl.valid = s1_valid;
  assign mac_ctl.first = s1_first;
  assign mac_ctl.last  = (s1_idx == '0);

  firdf_mac #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .tap  (tap_val),
    .coef (cf_rdata),
    .done (mac_done),
    .res  (mac_res)
  );

`ifndef NO_ASSERTIONS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_WAIT)
    else $error("MAC result outside wait state");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> run_idx <= tap_last)
    else $error("tap index beyond active taps");

  a_filter_starts: assert property (@(posedge clk) disable iff (rst)
    item_take && item.mode == firdf_pkg::MODE_FILTER && !fault |=> state == ST_RUN)
    else $error("filter item did not start the tap walk");
`endif

endmodule

// ===== bench/fir_filter_checker.sv =====
// ----------------------------------------------------------------------------
// FIR filter checker
// Tracks register writes and accepted items on the ports, predicts each
// filter output and compares it with the outputs the block transfers.
// ----------------------------------------------------------------------------
module fir_filter_checker #(
  parameter int MAX_TAPS       = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               item_valid,
  input  logic               item_ready,
  input  firdf_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  firdf_pkg::result_t result,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import firdf_pkg::*;

  logic signed [SAMPLE_W-1:0] history [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coefs [MAX_TAPS];
  logic [6:0]                 tap_setting;
  logic                       fault_on;
  result_t                    due_outputs [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic log_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  // Filter arithmetic: exact sum of products, round half up, floor shift, saturate.
  task automatic absorb_item(input item_t it);
    int                  n;
    logic signed [31:0]  prod;
    logic signed [63:0]  acc;
    logic signed [63:0]  y;
    result_t             r;
    case (it.mode)
      MODE_LOAD: begin
        coefs[it.tap_index] = it.coefficient;
      end
      MODE_CLEAR: begin
        if (!fault_on) begin
          for (int k = 0; k < MAX_TAPS; k++) history[k] = '0;
        end
      end
      MODE_FILTER: begin
        r = '0;
        if (!fault_on) begin
          if (tap_setting == 0) n = 1;
          else if (tap_setting > MAX_TAPS) n = MAX_TAPS;
          else n = tap_setting;
          for (int k = n - 1; k >= 1; k--) history[k] = history[k-1];
          history[0] = it.sample;
          acc = '0;
          for (int k = 0; k < n; k++) begin
            prod = history[k] * coefs[k];
            acc  = acc + prod;
          end
          acc = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
          y   = acc >>> COEF_FRAC_BITS;
          if (y > 64'sd32767) begin
            r.filtered = 16'sh7fff;
            r.clipped  = 1'b1;
          end else if (y < -64'sd32768) begin
            r.filtered = 16'sh8000;
            r.clipped  = 1'b1;
          end else begin
            r.filtered = y[SAMPLE_W-1:0];
          end
        end
        due_outputs.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        history[k] = '0;
        coefs[k]   = '0;
      end
      tap_setting = TAP_COUNT_RESET;
      fault_on    = 1'b0;
      due_outputs.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_TAP_COUNT: tap_setting = pwdata[6:0];
          REG_FAULT:     fault_on    = pwdata[0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (due_outputs.size() == 0) begin
          log_failure($sformatf("unexpected result: filtered %0d clipped %0b",
                                result.filtered, result.clipped));
        end else begin
          want = due_outputs.pop_front();
          if (result.filtered !== want.filtered || result.clipped !== want.clipped) begin
            log_failure($sformatf(
              "result mismatch: expected filtered %0d clipped %0b, got filtered %0d clipped %0b",
              want.filtered, want.clipped, result.filtered, result.clipped));
          end
        end
      end
      if (item_valid && item_ready) begin
        absorb_item(item);
      end
    end
    outstanding = due_outputs.size();
  end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// FIR filter testbench
// Directed corner items, then random phases over several tap count and fault
// settings, with bursty item traffic and a stalling output side.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import firdf_pkg::*;

  localparam int         MAX_TAPS       = 64;
  localparam int         COEF_FRAC_BITS = 15;
  localparam int         LATENCY        = MAX_TAPS + 16;
  localparam int         CYCLE_LIMIT    = 400000;
  localparam int         PHASE_ITEMS    = 36;
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  int          fail_count;
  int          outstanding;
  int          cycles;
  int          burst_left;

  fir_filter_direct_form_unit #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  fir_filter_checker #(
    .MAX_TAPS       (MAX_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) fir_chk (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: open stretches, short stalls and long stalls.
  initial begin
    int   run_left;
    logic level;
    result_ready = 1'b0;
    run_left     = 0;
    level        = 1'b0;
    forever begin
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin level = 1'b1; run_left = $urandom_range(20, 200); end
          1: begin level = 1'b0; run_left = $urandom_range(1, 3); end
          2: begin level = 1'b0; run_left = $urandom_range(10, 40); end
          default: begin level = 1'($urandom_range(0, 1)); run_left = $urandom_range(1, 8); end
        endcase
      end
      @(negedge clk);
      result_ready <= level;
      run_left--;
    end
  end

  function automatic item_t make_item(input logic [1:0] mode, input logic [15:0] sample,
                                      input logic [5:0] idx, input logic [15:0] coef);
    item_t it;
    it.mode        = mode;
    it.sample      = sample;
    it.tap_index   = idx;
    it.coefficient = coef;
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it.tap_index = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 68) it.mode = MODE_FILTER;
    else if (pick < 88) it.mode = MODE_LOAD;
    else if (pick < 94) it.mode = MODE_CLEAR;
    else it.mode = MODE_SPARE;
    case ($urandom_range(0, 4))
      0: it.sample = 16'($urandom_range(0, 511)) - 16'd256;
      1: begin
        case ($urandom_range(0, 3))
          0: it.sample = 16'sh7fff;
          1: it.sample = 16'sh8000;
          2: it.sample = 16'sh0000;
          default: it.sample = 16'shffff;
        endcase
      end
      default: it.sample = 16'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) it.coefficient = 16'($urandom);
    else it.coefficient = 16'($urandom_range(0, 8191)) - 16'd4096;
    return it;
  endfunction

  // Bursty sender: valid held across a burst, random gaps between bursts.
  task automatic send(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    item       <= it;
    item_valid <= 1'b1;
    burst_left--;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Idle the item side until every output is in and result-less work is done.
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic reg_write(input logic which, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [6:0] tap_plan [10];
    logic       fault_plan [10];
    item_t      it;
    int         counted;
    tap_plan   = '{7'd64, 7'd2, 7'd17, 7'd1, 7'd127, 7'd0, 7'd33, 7'd64, 7'd100, 7'd8};
    fault_plan = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    cycles       = 0;
    burst_left   = 0;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    item_valid   = 1'b0;
    item         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: all coefficients zero, then extremes at the table ends
    send(make_item(MODE_FILTER, 16'h7fff, 6'd0, 16'h0000));
    send(make_item(MODE_LOAD, 16'h0000, 6'd0, 16'h7fff));
    send(make_item(MODE_LOAD, 16'h0000, 6'd63, 16'h8000));
    send(make_item(MODE_LOAD, 16'h0000, 6'd1, 16'hffff));
    send(make_item(MODE_FILTER, 16'h7fff, 6'd0, 16'h0000));
    send(make_item(MODE_FILTER, 16'h8000, 6'd0, 16'h0000));
    send(make_item(MODE_FILTER, 16'hffff, 6'd0, 16'h0000));
    send(make_item(MODE_SPARE, 16'($urandom), 6'($urandom), 16'($urandom)));
    send(make_item(MODE_CLEAR, 16'h0000, 6'd0, 16'h0000));
    send(make_item(MODE_FILTER, 16'h8000, 6'd0, 16'h0000));

    // single tap: positive saturation
    settle();
    reg_write(REG_TAP_COUNT, 32'd1);
    send(make_item(MODE_LOAD, 16'h0000, 6'd0, 16'h8000));
    send(make_item(MODE_FILTER, 16'h8000, 6'd0, 16'h0000));
    send(make_item(MODE_FILTER, 16'h7fff, 6'd0, 16'h0000));

    // two taps: negative saturation
    settle();
    reg_write(REG_TAP_COUNT, 32'd2);
    send(make_item(MODE_LOAD, 16'h0000, 6'd1, 16'h8000));
    send(make_item(MODE_FILTER, 16'h7fff, 6'd0, 16'h0000));
    send(make_item(MODE_FILTER, 16'h7fff, 6'd0, 16'h0000));

    // zero taps behaves as one
    settle();
    reg_write(REG_TAP_COUNT, 32'd0);
    send(make_item(MODE_FILTER, 16'h0001, 6'd0, 16'h0000));

    // tap count above the table size
    settle();
    reg_write(REG_TAP_COUNT, 32'hffff_ff80 | 32'd127);
    send(make_item(MODE_FILTER, 16'h8000, 6'd0, 16'h0000));

    // fault: zero output, delay line frozen, clear suppressed, loads still land
    settle();
    reg_write(REG_FAULT, 32'd1);
    send(make_item(MODE_FILTER, 16'h1234, 6'd0, 16'h0000));
    send(make_item(MODE_CLEAR, 16'h0000, 6'd0, 16'h0000));
    send(make_item(MODE_LOAD, 16'h0000, 6'd2, 16'h4000));

    settle();
    reg_write(REG_FAULT, 32'hffff_fffe);
    reg_write(REG_TAP_COUNT, 32'd3);
    send(make_item(MODE_FILTER, 16'h0100, 6'd0, 16'h0000));
    send(make_item(MODE_FILTER, 16'h8000, 6'd0, 16'h0000));

    for (int p = 0; p < 10; p++) begin
      settle();
      reg_write(REG_TAP_COUNT, {25'($urandom), tap_plan[p]});
      reg_write(REG_FAULT, {31'($urandom), fault_plan[p]});
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = rand_item();
        send(it);
        if (it.mode != MODE_SPARE) counted++;
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
